// ===== src/msp_pkg.sv =====
// msp_pkg: shared types and codes for the multi-stack shared-pool block
// used by msp_ctrl, msp_datapath and multi_stack_shared_pool; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

    localparam int unsigned ID_W    = 4;
    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_BAD_ID = 2'd3
    } msp_status_t;

    typedef enum logic {
        MSP_IDLE,
        MSP_EXEC
    } msp_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH_FREE,
        OP_PUSH_FRESH,
        OP_POP
    } msp_op_t;

    typedef struct packed {
        logic        load;
        logic        exec;
        msp_op_t     op;
        msp_status_t code;
    } msp_cmd_t;

    typedef struct packed {
        logic bad_id;
        logic is_pop;
        logic top_empty;
        logic free_empty;
        logic fresh_full;
    } msp_flags_t;

endpackage : msp_pkg

`default_nettype wire

// ===== src/msp_ctrl.sv =====
// msp_ctrl: two-state controller, input and result handshakes, operation choice
// depends on msp_pkg; drives msp_datapath through msp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module msp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire msp_pkg::msp_flags_t flags,
    output msp_pkg::msp_cmd_t       cmd
);
    import msp_pkg::*;

    msp_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= MSP_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.code     = STAT_OK;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            MSP_IDLE: begin
                s_ready  = aresetn && (!m_valid_reg || m_ready);
                cmd.load = s_valid && s_ready;
                if (cmd.load) begin
                    state_next = MSP_EXEC;
                end
            end
            MSP_EXEC: begin
                cmd.exec     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = MSP_IDLE;
                if (flags.bad_id) begin
                    cmd.code = STAT_BAD_ID;
                end else if (flags.is_pop) begin
                    if (flags.top_empty) begin
                        cmd.code = STAT_EMPTY;
                    end else begin
                        cmd.op = OP_POP;
                    end
                end else if (!flags.free_empty) begin
                    cmd.op = OP_PUSH_FREE;
                end else if (!flags.fresh_full) begin
                    cmd.op = OP_PUSH_FRESH;
                end else begin
                    cmd.code = STAT_FULL;
                end
            end
            default: begin
                state_next = MSP_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == MSP_EXEC))
        else $error("result appeared without an execute cycle");

    a_no_load_over_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("item accepted while result slot still held");

    a_exec_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MSP_EXEC) |=> (state_reg == MSP_IDLE) && m_valid_reg)
        else $error("execute did not finish in one cycle");
`endif

endmodule : msp_ctrl

`default_nettype wire

// ===== src/msp_datapath.sv =====
// msp_datapath: top pointers, free list head, fresh counter, node memories, result
// depends on msp_pkg; commanded by msp_ctrl
`timescale 1ns / 1ps
`default_nettype none

module msp_datapath #(
    parameter int unsigned NUM_STACKS = 8,
    parameter int unsigned POOL_DEPTH = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_action,
    input  wire logic        [msp_pkg::ID_W-1:0]     s_stack_id,
    input  wire logic signed [msp_pkg::VALUE_W-1:0]  s_value,
    input  wire msp_pkg::msp_cmd_t                   cmd,
    output msp_pkg::msp_flags_t                      flags,
    output logic signed      [msp_pkg::VALUE_W-1:0]  m_popped_value,
    output logic             [1:0]                   m_status
);
    import msp_pkg::*;

    localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
    localparam int unsigned SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PW-1:0] EMPTY = PW'(POOL_DEPTH);

    function automatic logic [PW-1:0] clamp(input logic [PW-1:0] p);
        return (p < EMPTY) ? p : EMPTY;
    endfunction

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return ({1'b0, id} < (ID_W + 1)'(NUM_STACKS));
    endfunction

    logic [PW-1:0]             top_reg [NUM_STACKS];
    logic [PW-1:0]             free_head_reg;
    logic [PW-1:0]             fresh_count_reg;
    logic                      action_reg;
    logic [ID_W-1:0]           sid_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic signed [VALUE_W-1:0] node_value [POOL_DEPTH];
    logic [PW-1:0]             node_link  [POOL_DEPTH];
    logic signed [VALUE_W-1:0] value_rd_reg;
    logic [PW-1:0]             link_rd_reg;

    logic signed [VALUE_W-1:0] popped_reg;
    msp_status_t               status_reg;

    // load cycle: read the node that execute will need
    logic [PW-1:0] in_top;
    logic [PW-1:0] rd_ptr;
    logic          rd_en;

    always_comb begin
        in_top = id_ok(s_stack_id) ? clamp(top_reg[s_stack_id[SW-1:0]]) : EMPTY;
        rd_ptr = s_action ? in_top : clamp(free_head_reg);
        rd_en  = cmd.load && (rd_ptr != EMPTY);
    end

    // execute cycle
    logic          cur_ok;
    logic [PW-1:0] cur_top;
    logic [PW-1:0] new_node;
    logic          val_we;
    logic          link_we;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] link_wd;

    always_comb begin
        cur_ok           = id_ok(sid_reg);
        cur_top          = cur_ok ? clamp(top_reg[sid_reg[SW-1:0]]) : EMPTY;
        flags.bad_id     = !cur_ok;
        flags.is_pop     = action_reg;
        flags.top_empty  = (cur_top == EMPTY);
        flags.free_empty = (clamp(free_head_reg) == EMPTY);
        flags.fresh_full = (fresh_count_reg >= EMPTY);
        new_node         = (cmd.op == OP_PUSH_FREE) ? free_head_reg : fresh_count_reg;
        val_we           = cmd.exec && ((cmd.op == OP_PUSH_FREE) || (cmd.op == OP_PUSH_FRESH));
        link_we          = val_we || (cmd.exec && (cmd.op == OP_POP));
        wr_addr          = (cmd.op == OP_POP) ? cur_top[AW-1:0] : new_node[AW-1:0];
        link_wd          = (cmd.op == OP_POP) ? clamp(free_head_reg) : cur_top;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            sid_reg    <= s_stack_id;
            value_reg  <= s_value;
        end
        if (rd_en) begin
            value_rd_reg <= node_value[rd_ptr[AW-1:0]];
            link_rd_reg  <= node_link[rd_ptr[AW-1:0]];
        end
        if (val_we) begin
            node_value[wr_addr] <= value_reg;
        end
        if (link_we) begin
            node_link[wr_addr] <= link_wd;
        end
        if (cmd.exec) begin
            popped_reg <= (cmd.op == OP_POP) ? value_rd_reg : '0;
            status_reg <= cmd.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                top_reg[i] <= EMPTY;
            end
            free_head_reg   <= EMPTY;
            fresh_count_reg <= '0;
        end else if (cmd.exec) begin
            case (cmd.op)
                OP_PUSH_FREE: begin
                    top_reg[sid_reg[SW-1:0]] <= new_node;
                    free_head_reg            <= clamp(link_rd_reg);
                end
                OP_PUSH_FRESH: begin
                    top_reg[sid_reg[SW-1:0]] <= new_node;
                    fresh_count_reg          <= fresh_count_reg + PW'(1);
                end
                OP_POP: begin
                    top_reg[sid_reg[SW-1:0]] <= clamp(link_rd_reg);
                    free_head_reg            <= cur_top;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_popped_value = popped_reg;
    assign m_status       = status_reg;

`ifndef SYNTHESIS
    a_fresh_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_count_reg <= EMPTY)
        else $error("fresh counter beyond pool depth");

    a_pop_frees_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (cmd.op == OP_POP)) |=> (free_head_reg == $past(cur_top)))
        else $error("popped node not placed at free list head");

    a_push_sets_top: assert property (@(posedge aclk) disable iff (!aresetn)
        val_we |=> (clamp(top_reg[sid_reg[SW-1:0]]) == $past(new_node)))
        else $error("pushed node not placed at stack top");
`endif

endmodule : msp_datapath

`default_nettype wire

// ===== src/multi_stack_shared_pool.sv =====
// multi_stack_shared_pool: top level joining msp_ctrl and msp_datapath
// depends on msp_pkg, msp_ctrl, msp_datapath
//
// Several LIFO stacks share one pool of POOL_DEPTH nodes, each holding a value
// and a link. Freed nodes go to a free list; unused nodes come from a counter.
// Input channel s_*: one item is a push (s_action 0) or a pop (s_action 1)
// on stack s_stack_id; s_value is the value for a push.
// Result channel m_*: one result per item, m_popped_value (zero unless a pop
// succeeds) and m_status (ok, pop on empty, pool full, bad stack id).
// Timing: the item is accepted in the load step; the result is registered at
// the end of the execute step that follows, and m_valid rises with it.
// A new item is not taken while one is in execute; the load step reads the
// node memory (synchronous read of link and value), execute updates pointers.
// A stalled result stays in the output register; a new item is taken once
// that register is free or is being emptied in the same cycle.
// Reset: all stacks empty, free list empty, counter zero; node memory is not
// cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_shared_pool #(
    parameter int unsigned NUM_STACKS = 8,
    parameter int unsigned POOL_DEPTH = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic        [msp_pkg::ID_W-1:0]     s_stack_id,
    input  wire logic signed [msp_pkg::VALUE_W-1:0]  s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [msp_pkg::VALUE_W-1:0]  m_popped_value,
    output logic             [1:0]                   m_status
);
    import msp_pkg::*;

    msp_cmd_t   cmd;
    msp_flags_t flags;

    msp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    msp_datapath #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_action       (s_action),
        .s_stack_id     (s_stack_id),
        .s_value        (s_value),
        .cmd            (cmd),
        .flags          (flags),
        .m_popped_value (m_popped_value),
        .m_status       (m_status)
    );

endmodule : multi_stack_shared_pool

`default_nettype wire
